// File: rtl/cbd_pkg.sv
// cbd_pkg: shared types, address map constants and the read decode function
// for the cpu bus decoder with sprite dma
// no dependencies
`default_nettype none

package cbd_pkg;

	// bus command codes
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// where the byte of a read comes from
	typedef enum logic [2:0] {
		SRC_NONE  = 3'd0,
		SRC_CART  = 3'd1,
		SRC_RAM   = 3'd2,
		SRC_PPU   = 3'd3,
		SRC_FF    = 3'd4,
		SRC_LATCH = 3'd5
	} src_t;

	// address map
	localparam logic [15:0] RAM_TOP     = 16'h1FFF;
	localparam logic [15:0] PPU_LO      = 16'h2000;
	localparam logic [15:0] PPU_HI      = 16'h3FFF;
	localparam logic [15:0] IO_FF_LO    = 16'h4000;
	localparam logic [15:0] IO_FF_HI    = 16'h4017;
	localparam logic [15:0] OAM_DMA     = 16'h4014;
	localparam logic [15:0] IO_ZERO_LO  = 16'h4018;
	localparam logic [15:0] IO_ZERO_HI  = 16'h401F;
	localparam logic [7:0]  IO_FF_BYTE  = 8'hFF;
	localparam int          PPU_REG_W   = 3;
	localparam logic [7:0]  LAST_INDEX  = 8'hFF;

	// dma controller result for one word
	typedef struct packed {
		logic        fetch;
		logic        put;
		logic [7:0]  oam_index;
		logic [15:0] src_addr;
		logic        busy;
		logic [15:0] source;
	} dma_act_t;

	// decode a read address into its data source
	function automatic src_t read_src(logic [15:0] a, logic hit);
		src_t s;
		if (hit) begin
			s = SRC_CART;
		end else if (a <= RAM_TOP) begin
			s = SRC_RAM;
		end else if (a >= PPU_LO && a <= PPU_HI) begin
			s = SRC_PPU;
		end else if (a >= IO_FF_LO && a <= IO_FF_HI) begin
			s = SRC_FF;
		end else if (a >= IO_ZERO_LO && a <= IO_ZERO_HI) begin
			s = SRC_NONE;
		end else begin
			s = SRC_LATCH;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/cbd_dma.sv
// cbd_dma: sprite dma control state (page, index, running, wait and fetched-byte flags)
// depends on cbd_pkg
`default_nettype none

module cbd_dma (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [1:0]        cmd,
	input  wire logic [15:0]       addr,
	input  wire logic [7:0]        wdata,
	input  wire logic              cart_hit,
	input  wire logic              cycle_odd,
	output cbd_pkg::dma_act_t      act
);

	logic [7:0] page_q;
	logic [7:0] index_q;
	logic       running_q;
	logic       waiting_q;
	logic       byte_valid_q;

	logic [7:0] page_d;
	logic [7:0] index_d;
	logic       running_d;
	logic       waiting_d;
	logic       byte_valid_d;
	logic       fetch;
	logic       put;

	// next state for the current word
	always_comb begin
		page_d       = page_q;
		index_d      = index_q;
		running_d    = running_q;
		waiting_d    = waiting_q;
		byte_valid_d = byte_valid_q;
		fetch        = 1'b0;
		put          = 1'b0;
		if (cmd == cbd_pkg::CMD_WRITE && !cart_hit && addr == cbd_pkg::OAM_DMA) begin
			page_d       = wdata;
			index_d      = 8'd0;
			running_d    = 1'b1;
			waiting_d    = 1'b1;
			byte_valid_d = 1'b0;
		end else if (cmd == cbd_pkg::CMD_TICK && running_q) begin
			if (waiting_q) begin
				if (!cycle_odd) begin
					waiting_d = 1'b0;
				end
			end else if (!cycle_odd) begin
				fetch        = 1'b1;
				byte_valid_d = 1'b1;
			end else if (byte_valid_q) begin
				put          = 1'b1;
				byte_valid_d = 1'b0;
				index_d      = index_q + 8'd1;
				if (index_q == cbd_pkg::LAST_INDEX) begin
					running_d = 1'b0;
					waiting_d = 1'b0;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q       <= 8'd0;
			index_q      <= 8'd0;
			running_q    <= 1'b0;
			waiting_q    <= 1'b0;
			byte_valid_q <= 1'b0;
		end else if (acc) begin
			page_q       <= page_d;
			index_q      <= index_d;
			running_q    <= running_d;
			waiting_q    <= waiting_d;
			byte_valid_q <= byte_valid_d;
		end
	end

	assign act.fetch     = fetch;
	assign act.put       = put;
	assign act.oam_index = index_q;
	assign act.src_addr  = {page_q, index_q};
	assign act.busy      = running_d;
	assign act.source    = {page_d, index_d};

	// a put only follows a fetch
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && put |-> byte_valid_q)
		else $error("put without fetched byte");

	// waiting only while running
	assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q |-> running_q)
		else $error("dma waiting while idle");

	// no fetch or put while waiting for the first even tick
	assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q |-> !fetch && !put)
		else $error("dma transfer during wait");

endmodule

`default_nettype wire

// File: rtl/cpu_bus_decoder_with_sprite_dma_top.sv
// cpu_bus_decoder_with_sprite_dma_top: bus decode, work ram and sprite dma datapath
// depends on cbd_pkg and cbd_dma
`default_nettype none

// One word (bus read, bus write or dma tick) is taken every clock while
// in_stall is low; it is registered into stage 1 as the work ram read is
// issued, then loaded into the output register as one result word. Work ram
// is a single-port synchronous memory; after reset it is swept to zero, one
// entry a cycle, and in_stall stays high until the sweep ends, so no word is
// taken before it. Open-bus latch and the fetched dma byte are kept at the
// output stage, so back-to-back dependent words need no bubbles.
module cpu_bus_decoder_with_sprite_dma_top #(
	parameter int RAM_BYTES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] addr,
	input  wire logic [7:0]  wdata,
	input  wire logic        cart_hit,
	input  wire logic [7:0]  cart_data,
	input  wire logic [7:0]  ppu_data,
	input  wire logic        cycle_odd,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       rdata,
	output logic             ppu_read,
	output logic             ppu_write,
	output logic [2:0]       ppu_reg,
	output logic [7:0]       ppu_wdata,
	output logic             oam_write,
	output logic [7:0]       oam_index,
	output logic [7:0]       oam_data,
	output logic             dma_busy,
	output logic [15:0]      dma_source
);

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0] mem [RAM_BYTES];

	logic              in_acc;
	logic              adv;
	cbd_pkg::dma_act_t act;

	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;

	logic [15:0]       rd_addr;
	cbd_pkg::src_t     rd_src;
	logic              is_read;
	logic              ram_we;

	logic              valid_s1;
	cbd_pkg::src_t     src_s1;
	logic [7:0]        ram_rd_s1;
	logic [7:0]        cart_data_s1;
	logic [7:0]        ppu_data_s1;
	logic              fetch_s1;
	logic              put_s1;
	logic [7:0]        oam_index_s1;
	logic              ppu_write_s1;
	logic [2:0]        ppu_reg_s1;
	logic [7:0]        ppu_wdata_s1;
	logic              busy_s1;
	logic [15:0]       source_s1;

	logic [7:0]        bus_latch_q;
	logic [7:0]        dma_byte_q;
	logic [7:0]        sel_byte;
	logic              out_valid_q;

	// handshake
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = clr_busy_q || (valid_s1 && !adv);
	assign in_acc   = in_valid && !in_stall;

	cbd_dma u_dma (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (in_acc),
		.cmd       (cmd),
		.addr      (addr),
		.wdata     (wdata),
		.cart_hit  (cart_hit),
		.cycle_odd (cycle_odd),
		.act       (act)
	);

	// read path decode, shared by bus reads and dma fetches
	assign is_read = (cmd == cbd_pkg::CMD_READ) || act.fetch;
	assign rd_addr = act.fetch ? act.src_addr : addr;
	assign rd_src  = is_read ? cbd_pkg::read_src(rd_addr, cart_hit) : cbd_pkg::SRC_NONE;
	assign ram_we  = in_acc && cmd == cbd_pkg::CMD_WRITE && !cart_hit &&
		addr <= cbd_pkg::RAM_TOP;

	// work ram: clearing sweep after reset, then bus writes; registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 8'd0;
		end else if (ram_we) begin
			mem[addr[AW-1:0]] <= wdata;
		end
		if (in_acc) begin
			ram_rd_s1 <= mem[rd_addr[AW-1:0]];
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(RAM_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_s1       <= rd_src;
			cart_data_s1 <= cart_data;
			ppu_data_s1  <= ppu_data;
			fetch_s1     <= act.fetch;
			put_s1       <= act.put;
			oam_index_s1 <= act.put ? act.oam_index : 8'd0;
			busy_s1      <= act.busy;
			source_s1    <= act.source;
			ppu_write_s1 <= 1'b0;
			ppu_reg_s1   <= '0;
			ppu_wdata_s1 <= 8'd0;
			if (rd_src == cbd_pkg::SRC_PPU) begin
				ppu_reg_s1 <= rd_addr[cbd_pkg::PPU_REG_W-1:0];
			end else if (cmd == cbd_pkg::CMD_WRITE && !cart_hit &&
				addr >= cbd_pkg::PPU_LO && addr <= cbd_pkg::PPU_HI) begin
				ppu_write_s1 <= 1'b1;
				ppu_reg_s1   <= addr[cbd_pkg::PPU_REG_W-1:0];
				ppu_wdata_s1 <= wdata;
			end
		end
	end

	// read data select at the output stage
	always_comb begin
		case (src_s1)
			cbd_pkg::SRC_CART:  sel_byte = cart_data_s1;
			cbd_pkg::SRC_RAM:   sel_byte = ram_rd_s1;
			cbd_pkg::SRC_PPU:   sel_byte = ppu_data_s1;
			cbd_pkg::SRC_FF:    sel_byte = cbd_pkg::IO_FF_BYTE;
			cbd_pkg::SRC_LATCH: sel_byte = bus_latch_q;
			default:            sel_byte = 8'd0;
		endcase
	end

	// bus latch, fetched byte and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_latch_q <= 8'd0;
			dma_byte_q  <= 8'd0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				if (src_s1 == cbd_pkg::SRC_CART || src_s1 == cbd_pkg::SRC_RAM ||
					src_s1 == cbd_pkg::SRC_PPU) begin
					bus_latch_q <= sel_byte;
				end
				if (fetch_s1) begin
					dma_byte_q <= sel_byte;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rdata      <= sel_byte;
			ppu_read   <= (src_s1 == cbd_pkg::SRC_PPU);
			ppu_write  <= ppu_write_s1;
			ppu_reg    <= ppu_reg_s1;
			ppu_wdata  <= ppu_wdata_s1;
			oam_write  <= put_s1;
			oam_index  <= oam_index_s1;
			oam_data   <= put_s1 ? dma_byte_q : 8'd0;
			dma_busy   <= busy_s1;
			dma_source <= source_s1;
		end
	end

	assign out_valid = out_valid_q;

	// a word never both fetches and puts
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(fetch_s1 && put_s1))
		else $error("fetch and put in one word");

	// a picture unit write never carries a read source
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ppu_write_s1 |-> src_s1 == cbd_pkg::SRC_NONE)
		else $error("write word with read source");

	// the clearing sweep ends only after the last entry
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_addr_q) == AW'(RAM_BYTES - 1))
		else $error("clearing sweep ended early");

	// a stalled stage-one word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(src_s1))
		else $error("stage one word lost under stall");

endmodule

`default_nettype wire
